// File: src/ids_pkg.sv
// Shared types and constants for the ignition dwell scheduler.
package ids_pkg;

   // Angle fixed point: sixteenths of a degree, one engine cycle is 720 degrees.
   localparam int ANGLE_FRAC_BITS = 4;
   localparam int ANGLE_WIDTH     = 14;
   localparam int CYCLE_FIXED     = 720 << ANGLE_FRAC_BITS;
   localparam logic [ANGLE_WIDTH-1:0] CYCLE_ANGLE = ANGLE_WIDTH'(CYCLE_FIXED);

   // Field widths of the transactions.
   localparam int NOW_WIDTH     = 32;
   localparam int RATE_WIDTH    = 16;
   localparam int DWELL_WIDTH   = 16;
   localparam int CH_WIDTH      = 2;
   localparam int TGT_COUNT     = 4;
   localparam int PROD_WIDTH    = RATE_WIDTH + ANGLE_WIDTH;
   localparam int OFFSET_WIDTH  = PROD_WIDTH - ANGLE_FRAC_BITS;
   localparam int CSR_IDX_WIDTH = 3;
   localparam int CSR_DAT_WIDTH = 16;

   // Command codes.
   localparam logic CMD_SCHEDULE = 1'b0;
   localparam logic CMD_MATCH    = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TGT_CH0 = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TGT_CH1 = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TGT_CH2 = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TGT_CH3 = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DWELL   = 3'd4;

   // Reset values of the configuration registers.
   localparam logic [ANGLE_WIDTH-1:0] TGT_RESET_CH0 = ANGLE_WIDTH'(90 << ANGLE_FRAC_BITS);
   localparam logic [ANGLE_WIDTH-1:0] TGT_RESET_CH1 = ANGLE_WIDTH'(270 << ANGLE_FRAC_BITS);
   localparam logic [ANGLE_WIDTH-1:0] TGT_RESET_CH2 = ANGLE_WIDTH'(450 << ANGLE_FRAC_BITS);
   localparam logic [ANGLE_WIDTH-1:0] TGT_RESET_CH3 = ANGLE_WIDTH'(630 << ANGLE_FRAC_BITS);
   localparam logic [DWELL_WIDTH-1:0] DWELL_RESET   = 16'd1000;

   // Channel status kept in the state memory.
   typedef enum logic [1:0] {
      ST_OFF     = 2'd0,
      ST_PENDING = 2'd1,
      ST_RUNNING = 2'd2
   } status_type;

   // Result action codes.
   typedef enum logic [2:0] {
      ACT_SCHEDULED = 3'd0,
      ACT_INVALID   = 3'd1,
      ACT_IN_PAST   = 3'd2,
      ACT_COIL_ON   = 3'd3,
      ACT_COIL_OFF  = 3'd4,
      ACT_FAULT     = 3'd5
   } action_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_CALC,
      FSM_MUL,
      FSM_ADD,
      FSM_DONE
   } fsm_type;

   // Request transaction payload.
   typedef struct packed {
      logic                     cmd;
      logic [CH_WIDTH-1:0]      channel;
      logic [ANGLE_WIDTH-1:0]   crank_angle;
      logic                     angle_valid;
      logic [NOW_WIDTH-1:0]     now_us;
      logic [RATE_WIDTH-1:0]    us_per_degree;
      logic                     rate_valid;
   } req_type;

   // Result transaction payload.
   typedef struct packed {
      logic [CH_WIDTH-1:0]      out_channel;
      action_type               action;
      logic                     coil_on;
      logic [NOW_WIDTH-1:0]     compare_time;
      logic                     finished;
   } rsp_type;

   // Configuration register contents.
   typedef struct packed {
      logic [TGT_COUNT-1:0][ANGLE_WIDTH-1:0] target_angle;
      logic [DWELL_WIDTH-1:0]                dwell_us;
   } cfg_type;

   // Stage enables from the sequencer to the timing datapath.
   typedef struct packed {
      logic calc;
      logic mul;
      logic add;
   } stage_en_type;

endpackage

// File: src/ignition_dwell_scheduler_core.sv
// Ignition dwell scheduler top level: sequencer, state read-modify-write, result register.
// The channel state is read as a transaction is accepted; it then steps through the calc,
// multiply, add and done states, the done state writing back the channel state and setting
// the registered result strobe. Busy stays high in these states: no new transaction is taken.
// The receiver cannot stall; results are strobed for one cycle. Synchronous reset turns
// every channel off and restores the configuration defaults; no clearing pass is needed.
module ignition_dwell_scheduler_core #(
   parameter int CHANNELS   = 4,
   parameter int TIME_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  ids_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   output ids_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ids_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [ids_pkg::CSR_DAT_WIDTH-1:0] csr_wdata
);

   localparam int AddrWidth = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   ids_pkg::fsm_type      state_ff;
   ids_pkg::fsm_type      state_in;
   ids_pkg::stage_en_type stage_en;
   ids_pkg::req_type      req_ff;
   ids_pkg::cfg_type      cfg;
   ids_pkg::rsp_type      rsp_data_ff;
   ids_pkg::rsp_type      rsp_data_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  accept;
   ids_pkg::status_type   rd_status;
   logic [TIME_WIDTH-1:0] rd_spark;
   logic                  wr_en;
   ids_pkg::status_type   wr_status;
   logic [TIME_WIDTH-1:0] wr_spark;
   logic [TIME_WIDTH-1:0] spark_time;
   logic [TIME_WIDTH-1:0] start_time;
   logic                  in_past;
   logic                  ch_fault;
   logic                  running;

   assign accept = start && !busy;

   ids_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ids_state_mem #(
      .CHANNELS   (CHANNELS),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_state_mem (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr   (AddrWidth'(req_data.channel)),
      .rd_status (rd_status),
      .rd_spark  (rd_spark),
      .wr_en     (wr_en),
      .wr_addr   (AddrWidth'(req_ff.channel)),
      .wr_status (wr_status),
      .wr_spark  (wr_spark)
   );

   ids_timing #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_timing (
      .clock      (clock),
      .en         (stage_en),
      .req        (req_ff),
      .cfg        (cfg),
      .spark_time (spark_time),
      .start_time (start_time),
      .in_past    (in_past)
   );

   // Request holding register, loaded when a transaction is accepted.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ids_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequencer next state and stage enables.
   always_comb begin
      state_in      = state_ff;
      stage_en      = '0;
      busy          = 1'b1;
      rsp_valid_in  = 1'b0;
      case (state_ff)
         ids_pkg::FSM_IDLE: begin
            busy = 1'b0;
            if (start) begin
               state_in = ids_pkg::FSM_CALC;
            end
         end
         ids_pkg::FSM_CALC: begin
            stage_en.calc = 1'b1;
            state_in      = ids_pkg::FSM_MUL;
         end
         ids_pkg::FSM_MUL: begin
            stage_en.mul = 1'b1;
            state_in     = ids_pkg::FSM_ADD;
         end
         ids_pkg::FSM_ADD: begin
            stage_en.add = 1'b1;
            state_in     = ids_pkg::FSM_DONE;
         end
         ids_pkg::FSM_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = ids_pkg::FSM_IDLE;
         end
         default: begin
            state_in = ids_pkg::FSM_IDLE;
         end
      endcase
   end

   // Result and state update in the final step.
   assign ch_fault = (32'(req_ff.channel) >= CHANNELS);
   assign running  = (rd_status == ids_pkg::ST_RUNNING);

   always_comb begin
      rsp_data_in.out_channel  = req_ff.channel;
      rsp_data_in.action       = ids_pkg::ACT_FAULT;
      rsp_data_in.coil_on      = 1'b0;
      rsp_data_in.compare_time = '0;
      rsp_data_in.finished     = 1'b0;
      wr_en                    = 1'b0;
      wr_status                = rd_status;
      wr_spark                 = rd_spark;
      if (state_ff == ids_pkg::FSM_DONE && !ch_fault) begin
         if (req_ff.cmd == ids_pkg::CMD_SCHEDULE) begin
            if (!req_ff.angle_valid || !req_ff.rate_valid) begin
               rsp_data_in.action   = ids_pkg::ACT_INVALID;
               rsp_data_in.coil_on  = running;
               rsp_data_in.finished = 1'b1;
            end else if (in_past) begin
               // The spark time is kept even though the request is rejected.
               wr_en                = 1'b1;
               wr_spark             = spark_time;
               rsp_data_in.action   = ids_pkg::ACT_IN_PAST;
               rsp_data_in.coil_on  = running;
               rsp_data_in.finished = 1'b1;
            end else begin
               wr_en                    = 1'b1;
               wr_status                = ids_pkg::ST_PENDING;
               wr_spark                 = spark_time;
               rsp_data_in.action       = ids_pkg::ACT_SCHEDULED;
               rsp_data_in.compare_time = ids_pkg::NOW_WIDTH'(start_time);
            end
         end else begin
            case (rd_status)
               ids_pkg::ST_PENDING: begin
                  wr_en                    = 1'b1;
                  wr_status                = ids_pkg::ST_RUNNING;
                  rsp_data_in.action       = ids_pkg::ACT_COIL_ON;
                  rsp_data_in.coil_on      = 1'b1;
                  rsp_data_in.compare_time = ids_pkg::NOW_WIDTH'(rd_spark);
               end
               ids_pkg::ST_RUNNING: begin
                  wr_en                = 1'b1;
                  wr_status            = ids_pkg::ST_OFF;
                  rsp_data_in.action   = ids_pkg::ACT_COIL_OFF;
                  rsp_data_in.finished = 1'b1;
               end
               default: begin
                  rsp_data_in.action = ids_pkg::ACT_FAULT;
               end
            endcase
         end
      end
   end

   // Result register: each result is strobed for one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: src/ids_csr.sv
// Configuration registers: target angles per channel and the dwell time.
module ids_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ids_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [ids_pkg::CSR_DAT_WIDTH-1:0] csr_wdata,
   output ids_pkg::cfg_type                  cfg
);

   ids_pkg::cfg_type cfg_ff;
   ids_pkg::cfg_type cfg_in;

   // Writes are always taken; indexes past the list are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            ids_pkg::CSR_TGT_CH0: cfg_in.target_angle[0] = csr_wdata[ids_pkg::ANGLE_WIDTH-1:0];
            ids_pkg::CSR_TGT_CH1: cfg_in.target_angle[1] = csr_wdata[ids_pkg::ANGLE_WIDTH-1:0];
            ids_pkg::CSR_TGT_CH2: cfg_in.target_angle[2] = csr_wdata[ids_pkg::ANGLE_WIDTH-1:0];
            ids_pkg::CSR_TGT_CH3: cfg_in.target_angle[3] = csr_wdata[ids_pkg::ANGLE_WIDTH-1:0];
            ids_pkg::CSR_DWELL:   cfg_in.dwell_us        = csr_wdata[ids_pkg::DWELL_WIDTH-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_angle[0] <= ids_pkg::TGT_RESET_CH0;
         cfg_ff.target_angle[1] <= ids_pkg::TGT_RESET_CH1;
         cfg_ff.target_angle[2] <= ids_pkg::TGT_RESET_CH2;
         cfg_ff.target_angle[3] <= ids_pkg::TGT_RESET_CH3;
         cfg_ff.dwell_us        <= ids_pkg::DWELL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/ids_state_mem.sv
// Per-channel state memory holding status and spark time, with registered read.
module ids_state_mem #(
   parameter int CHANNELS   = 4,
   parameter int TIME_WIDTH = 32,
   localparam int AddrWidth = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [AddrWidth-1:0]     rd_addr,
   output ids_pkg::status_type      rd_status,
   output logic [TIME_WIDTH-1:0]    rd_spark,
   input  logic                     wr_en,
   input  logic [AddrWidth-1:0]     wr_addr,
   input  ids_pkg::status_type      wr_status,
   input  logic [TIME_WIDTH-1:0]    wr_spark
);

   localparam int WordWidth = TIME_WIDTH + 2;

   logic [WordWidth-1:0] mem [CHANNELS];
   logic [WordWidth-1:0] rd_word_ff;
   logic                 rd_valid_ff;
   logic [CHANNELS-1:0]  valid_ff;

   // Memory array: one write and one read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_status, wr_spark};
      end
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   // Entry valid bits; an entry never written reads as off.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_status = rd_valid_ff ? ids_pkg::status_type'(rd_word_ff[WordWidth-1 -: 2])
                                  : ids_pkg::ST_OFF;
   assign rd_spark  = rd_word_ff[TIME_WIDTH-1:0];

endmodule

// File: src/ids_timing.sv
// Timing datapath: angle to go, angle times rate, spark and dwell start times.
module ids_timing #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                  clock,
   input  ids_pkg::stage_en_type en,
   input  ids_pkg::req_type      req,
   input  ids_pkg::cfg_type      cfg,
   output logic [TIME_WIDTH-1:0] spark_time,
   output logic [TIME_WIDTH-1:0] start_time,
   output logic                  in_past
);

   logic [ids_pkg::ANGLE_WIDTH-1:0]  tgt_raw;
   logic [ids_pkg::ANGLE_WIDTH-1:0]  tgt_mod;
   logic [ids_pkg::ANGLE_WIDTH-1:0]  cur_mod;
   logic [ids_pkg::ANGLE_WIDTH-1:0]  delta_in;
   logic [ids_pkg::ANGLE_WIDTH-1:0]  delta_ff;
   logic [ids_pkg::PROD_WIDTH-1:0]   prod_ff;
   logic [ids_pkg::OFFSET_WIDTH-1:0] offset;
   logic [TIME_WIDTH-1:0]            now_t;
   logic [TIME_WIDTH-1:0]            spark_ff;

   // Angle to go: reduce both angles into one cycle, an equal angle is a full cycle.
   always_comb begin
      tgt_raw = cfg.target_angle[req.channel];
      tgt_mod = (tgt_raw >= ids_pkg::CYCLE_ANGLE) ? tgt_raw - ids_pkg::CYCLE_ANGLE : tgt_raw;
      cur_mod = (req.crank_angle >= ids_pkg::CYCLE_ANGLE) ?
                req.crank_angle - ids_pkg::CYCLE_ANGLE : req.crank_angle;
      if (tgt_mod > cur_mod) begin
         delta_in = tgt_mod - cur_mod;
      end else begin
         delta_in = ids_pkg::CYCLE_ANGLE - cur_mod + tgt_mod;
      end
   end

   assign offset = prod_ff[ids_pkg::PROD_WIDTH-1:ids_pkg::ANGLE_FRAC_BITS];
   assign now_t  = TIME_WIDTH'(req.now_us);

   // Pipeline registers: angle, product, spark time.
   always_ff @(posedge clock) begin
      if (en.calc) begin
         delta_ff <= delta_in;
      end
      if (en.mul) begin
         prod_ff <= ids_pkg::PROD_WIDTH'(req.us_per_degree) * ids_pkg::PROD_WIDTH'(delta_ff);
      end
      if (en.add) begin
         spark_ff <= now_t + TIME_WIDTH'(offset);
      end
   end

   // Dwell start and the check against the current time.
   assign spark_time = spark_ff;
   assign start_time = spark_ff - TIME_WIDTH'(cfg.dwell_us);
   assign in_past    = (start_time <= now_t);

endmodule
